FILE: rtl/ima_adpcm_4bit_decoder_assert.svh
// Assertion macros shared by the IMA ADPCM decoder checker.
// Needs no package; each macro takes its clock and active-low reset as arguments.
`ifndef IMA_ADPCM_4BIT_DECODER_ASSERT_SVH
`define IMA_ADPCM_4BIT_DECODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ima decoder assertion failed");

// antecedent implies consequent in the next cycle
`define IMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ima decoder assertion failed");

`endif

FILE: rtl/ima_pkg.sv
// Shared types, constants and tables for the IMA ADPCM 4-bit decoder.
// No dependencies; used by ima_dec_nibble and ima_adpcm_4bit_decoder.
package ima_pkg;

    localparam int PCM_W   = 16;
    localparam int IDX_W   = 7;
    localparam int CODE_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int STEP_W  = 15;
    localparam int DIFF_W  = 17;
    localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

    typedef logic signed [PCM_W-1:0] pcm_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [STEP_W-1:0]       step_t;

    // standard 89-entry step size table
    function automatic step_t step_size(input idx_t idx);
        step_t s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
            7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
            7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
            7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
            7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
            7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
            7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
            7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
            7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
            7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
            7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
            7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
            7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
            7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
            7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // index movement from the code magnitude (sign bit plays no part)
    function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        case (mag) inside
            [3'd0:3'd3]: a = -5'sd1;
            3'd4:        a = 5'sd2;
            3'd5:        a = 5'sd4;
            3'd6:        a = 5'sd6;
            3'd7:        a = 5'sd8;
            default:     a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/ima_dec_nibble.sv
// Single-nibble IMA ADPCM datapath: step lookup, difference, predictor saturation
// and index update. Depends on ima_pkg.
module ima_dec_nibble
(
    input  logic [ima_pkg::CODE_W-1:0] code,
    input  ima_pkg::pcm_t              pred,
    input  ima_pkg::idx_t              idx,
    output ima_pkg::pcm_t              sample,
    output ima_pkg::idx_t              idx_next
);

    ima_pkg::step_t                step;
    logic [ima_pkg::DIFF_W-1:0]    diff;
    logic signed [17:0]            pred_ext;
    logic signed [17:0]            diff_ext;
    logic signed [17:0]            sum;
    logic signed [4:0]             adj;
    logic signed [7:0]             idx_sum;

    always_comb
    begin
        step = ima_pkg::step_size(idx);
        diff = {5'd0, step[14:3]}
             + (code[2] ? {2'd0, step} : 17'd0)
             + (code[1] ? {3'd0, step[14:1]} : 17'd0)
             + (code[0] ? {4'd0, step[14:2]} : 17'd0);

        pred_ext = {{2{pred[15]}}, pred};
        diff_ext = {1'b0, diff};
        sum      = code[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

        if (sum > 18'sd32767)
            sample = 16'sh7FFF;
        else if (sum < -18'sd32768)
            sample = 16'sh8000;
        else
            sample = sum[15:0];

        adj     = ima_pkg::idx_adjust(code[2:0]);
        idx_sum = $signed({1'b0, idx}) + {{3{adj[4]}}, adj};
        if (idx_sum < 8'sd0)
            idx_next = '0;
        else if (idx_sum > $signed({1'b0, ima_pkg::IDX_MAX}))
            idx_next = ima_pkg::IDX_MAX;
        else
            idx_next = idx_sum[6:0];
    end

endmodule

FILE: rtl/ima_adpcm_4bit_decoder.sv
// IMA ADPCM 4-bit decoder top level: input byte register, nibble phase,
// decoder state and result register. Depends on ima_pkg and ima_dec_nibble.
//
// Usage:
//   The slave channel takes one request per code byte: tdata carries the byte,
//   tuser flags the first byte of a stream (predictor and step index cleared
//   before it is decoded), tlast flags the final byte.
//   The master channel gives two 16-bit PCM samples per byte, high nibble first;
//   tuser is high on the low-nibble sample and tlast is high on the low-nibble
//   sample of a tlast byte.
//   Path: a byte passes the input byte register, and its high-nibble sample the
//   result register, before that sample is offered; the low nibble enters the
//   result register at the edge on which the high-nibble sample is taken.
//   Throughput: one sample per cycle while the receiver does not stall, set by
//   the single nibble datapath feeding the result register; two samples per byte.
//   A new byte is taken in the same cycle as the low nibble of the previous one
//   is decoded, so the input side never waits on an empty datapath.
//   Reset clears predictor, step index and both valid flags.
//   When the receiver stalls, the result register holds its sample, decoding
//   stops and s_tready falls once the input byte register holds a byte.
module ima_adpcm_4bit_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pcm_sample
    output logic        m_tuser,   // [0] second_of_pair
    output logic        m_tlast
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_first_reg;
    logic                 in_last_reg;
    logic                 phase_reg;
    ima_pkg::pcm_t        pred_reg;
    ima_pkg::idx_t        idx_reg;
    logic                 out_valid_reg;
    ima_pkg::pcm_t        out_sample_reg;
    logic                 out_second_reg;
    logic                 out_end_reg;

    logic                 fire;
    logic                 accept;
    logic                 restart;
    logic [3:0]           code;
    ima_pkg::pcm_t        pred_in;
    ima_pkg::idx_t        idx_in;
    ima_pkg::pcm_t        sample;
    ima_pkg::idx_t        idx_next;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || (fire && phase_reg);
    assign accept   = s_tvalid && s_tready;

    // first byte decodes its high nibble from a cleared state
    assign restart  = in_first_reg && !phase_reg;
    assign code     = phase_reg ? in_byte_reg[3:0] : in_byte_reg[7:4];
    assign pred_in  = restart ? '0 : pred_reg;
    assign idx_in   = restart ? '0 : idx_reg;

    ima_dec_nibble u_nibble
    (
        .code     (code),
        .pred     (pred_in),
        .idx      (idx_in),
        .sample   (sample),
        .idx_next (idx_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            pred_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
                phase_reg    <= 1'b0;
            end
            else if (fire)
            begin
                // drop the byte once its low nibble is out
                in_valid_reg <= !phase_reg;
                phase_reg    <= !phase_reg;
            end

            if (fire)
            begin
                pred_reg      <= sample;
                idx_reg       <= idx_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (fire)
        begin
            out_sample_reg <= sample;
            out_second_reg <= phase_reg;
            out_end_reg    <= phase_reg && in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_second_reg;
    assign m_tlast  = out_end_reg;

endmodule

FILE: rtl/ima_dec_checker.sv
// Port-level checker for the IMA ADPCM decoder, bound to the top level.
// Depends on ima_adpcm_4bit_decoder_assert.svh.
`include "ima_adpcm_4bit_decoder_assert.svh"

module ima_dec_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic s_req;
    logic m_req;

    assign s_req = s_tvalid && s_tready;
    assign m_req = m_tvalid && m_tready;

    // a stalled result holds
    `IMA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // end of stream only on the low-nibble sample
    `IMA_ASSERT_SAME(a_end_on_second, clk, rst_n, m_tvalid && m_tlast, m_tuser)
    // a high-nibble sample is followed at once by its low-nibble partner
    `IMA_ASSERT_NEXT(a_pair_follows, clk, rst_n, m_req && !m_tuser, m_tvalid && m_tuser)
    // an accepted request shows a result once past the input byte and result registers
    `IMA_ASSERT_NEXT(a_result_due, clk, rst_n, s_req, ##1 m_tvalid)

endmodule

bind ima_adpcm_4bit_decoder ima_dec_checker u_ima_dec_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
